// File: design/alar_pkg.sv
// Shared widths, constants, register codes and types for the resampler.
`timescale 1ns / 1ps

package alar_pkg;

  // Field widths
  localparam int SampleW = 16;
  localparam int FillW   = 16;
  localparam int StepW   = 32;
  localparam int FracW   = 28;
  localparam int AdjW    = 31;
  localparam int AdjFracW = 30;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;

  // Output cap per input frame
  localparam int MaxOuts = 64;
  localparam int CntW    = $clog2(MaxOuts);

  // Rate control: adjustment is 1 + (fill - target) / (RateDiv * target)
  localparam int RateDiv = 200;
  localparam int DenW    = FillW + 8;
  localparam int MagW    = FillW;
  localparam int DvdW    = MagW + AdjFracW;

  // Q4.28 and Q1.30 constants
  localparam logic [StepW-1:0] OneQ28      = 32'h1000_0000;
  localparam logic [AdjW-1:0]  AdjOne      = 31'h4000_0000;
  localparam logic [AdjW-1:0]  AdjMin      = 31'd1063004405;
  localparam logic [AdjW-1:0]  AdjMax      = 31'd1084479242;
  localparam logic [DvdW-1:0]  AdjSpanLo   = DvdW'(AdjOne - AdjMin);
  localparam logic [DvdW-1:0]  AdjSpanHi   = DvdW'(AdjMax - AdjOne);

  // Register reset values
  localparam logic [StepW-1:0] BaseStepRst = 32'h1000_0000;
  localparam logic [FillW-1:0] TargetRst   = 16'd1440;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBaseStep    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetFrames = 8'd1;

  // Step recompute request from the sequencer
  typedef struct packed {
    logic             start;
    logic [FillW-1:0] fill_level;
    logic [FillW-1:0] target_frames;
  } alar_step_req_t;

endpackage

// File: design/alar_step_unit.sv
// Step recompute unit: serial divider, clamp and step multiply.
`timescale 1ns / 1ps

module alar_step_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  alar_pkg::alar_step_req_t     req,
  input  logic [alar_pkg::StepW-1:0]   base_step,
  output logic                         done,
  output logic [alar_pkg::StepW-1:0]   step
);

  localparam logic [2:0] SuIdle = 3'd0;
  localparam logic [2:0] SuDiv  = 3'd1;
  localparam logic [2:0] SuAdj  = 3'd2;
  localparam logic [2:0] SuMul  = 3'd3;
  localparam logic [2:0] SuDone = 3'd4;

  localparam int DivCntW = $clog2(alar_pkg::DvdW);
  localparam int ProdW   = alar_pkg::StepW + alar_pkg::AdjW;

  logic [2:0]                      st_r, st_nxt;
  logic [DivCntW-1:0]              cnt_r, cnt_nxt;
  logic [alar_pkg::DenW-1:0]       den_r, den_nxt;
  logic [alar_pkg::DenW-1:0]       rem_r, rem_nxt;
  logic [alar_pkg::DvdW-1:0]       dvd_r, dvd_nxt;
  logic                            neg_r, neg_nxt;
  logic [alar_pkg::AdjW-1:0]       adj_r, adj_nxt;
  logic [ProdW-1:0]                prod_r, prod_nxt;

  logic [alar_pkg::FillW-1:0]      tgt_fix;
  logic signed [alar_pkg::FillW:0] delta;
  logic [alar_pkg::FillW:0]        delta_abs;
  logic [alar_pkg::DenW:0]         trial;
  logic                            qbit;

  // Zero target counts as one; signed distance from target
  assign tgt_fix   = (req.target_frames == '0) ? alar_pkg::FillW'(1) : req.target_frames;
  assign delta     = $signed({1'b0, req.fill_level}) - $signed({1'b0, tgt_fix});
  assign delta_abs = delta[alar_pkg::FillW] ? (~delta + 1'b1) : delta;

  // Restoring divide step
  assign trial = {rem_r, dvd_r[alar_pkg::DvdW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    neg_nxt  = neg_r;
    adj_nxt  = adj_r;
    prod_nxt = prod_r;
    unique case (st_r)
      SuIdle: begin
        if (req.start) begin
          den_nxt = alar_pkg::DenW'(tgt_fix) * alar_pkg::DenW'(alar_pkg::RateDiv);
          dvd_nxt = {delta_abs[alar_pkg::MagW-1:0], {alar_pkg::AdjFracW{1'b0}}};
          neg_nxt = delta[alar_pkg::FillW];
          rem_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = SuDiv;
        end
      end
      SuDiv: begin
        rem_nxt = qbit ? alar_pkg::DenW'(trial - {1'b0, den_r})
                       : trial[alar_pkg::DenW-1:0];
        dvd_nxt = {dvd_r[alar_pkg::DvdW-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(alar_pkg::DvdW - 1)) begin
          st_nxt = SuAdj;
        end
      end
      SuAdj: begin
        // Clamp adjustment to [0.99, 1.01]
        if (neg_r) begin
          adj_nxt = (dvd_r > alar_pkg::AdjSpanLo) ? alar_pkg::AdjMin
                  : alar_pkg::AdjOne - dvd_r[alar_pkg::AdjW-1:0];
        end else begin
          adj_nxt = (dvd_r > alar_pkg::AdjSpanHi) ? alar_pkg::AdjMax
                  : alar_pkg::AdjOne + dvd_r[alar_pkg::AdjW-1:0];
        end
        st_nxt = SuMul;
      end
      SuMul: begin
        prod_nxt = ProdW'(base_step) * ProdW'(adj_r);
        st_nxt   = SuDone;
      end
      SuDone: begin
        st_nxt = SuIdle;
      end
      default: begin
        st_nxt = SuIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= SuIdle;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    neg_r  <= neg_nxt;
    adj_r  <= adj_nxt;
    prod_r <= prod_nxt;
  end

  // Shift right by 30, saturate to 32 bits
  assign done = (st_r == SuDone);
  assign step = prod_r[ProdW-1] ? '1 : prod_r[ProdW-2:alar_pkg::AdjFracW];

endmodule

// File: design/alar_lane.sv
// One channel of linear interpolation: registered multiply, then truncating scale.
`timescale 1ns / 1ps

module alar_lane (
  input  logic                               clk,
  input  logic                               issue,
  input  logic signed [alar_pkg::SampleW-1:0] prev,
  input  logic signed [alar_pkg::SampleW-1:0] cur,
  input  logic [alar_pkg::FracW-1:0]         frac,
  output logic signed [alar_pkg::SampleW-1:0] result
);

  localparam int DiffW = alar_pkg::SampleW + 1;
  localparam int ProdW = DiffW + alar_pkg::FracW + 1;
  localparam int NumW  = ProdW + 1;

  logic signed [DiffW-1:0]            diff;
  logic signed [ProdW-1:0]            prod_r;
  logic signed [alar_pkg::SampleW-1:0] prev_r;
  logic signed [NumW-1:0]             num;
  logic signed [NumW-1:0]             base_w;
  logic                               round_up;

  assign diff = DiffW'(cur) - DiffW'(prev);

  // Stage 1: slope times fraction
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= diff * $signed({1'b0, frac});
      prev_r <= prev;
    end
  end

  // prev * 2^28 + product, then divide by 2^28 toward zero
  assign base_w   = {{(NumW - alar_pkg::SampleW - alar_pkg::FracW){prev_r[alar_pkg::SampleW-1]}},
                     prev_r, {alar_pkg::FracW{1'b0}}};
  assign num      = base_w + NumW'(prod_r);
  assign round_up = num[NumW-1] && (num[alar_pkg::FracW-1:0] != '0);
  assign result   = num[alar_pkg::FracW +: alar_pkg::SampleW]
                  + {{(alar_pkg::SampleW-1){1'b0}}, round_up};

endmodule

// File: design/adaptive_linear_audio_resampler.sv
// Top level: config registers, frame sequencer, two channel lanes and output merge.
`timescale 1ns / 1ps

// Stereo linear-interpolation resampler with fill-level rate control.
// Input channel (in_valid / in_stall): one stereo frame per transfer; in_stall
// is high while a frame is being worked on. Output channel (out_valid /
// out_stall): interpolated stereo frames, out_last marks the final output
// caused by an input frame; a frame whose start position is already at or
// above 1.0 gives no output.
// An accepted frame starts the sequencer; each output then passes the stage 1
// register and the output register. With in_batch_start set the step is
// recomputed first by a bit-serial divider (46 steps) plus clamp and multiply.
// Throughput: one output per cycle while out_stall does not hold the pipeline,
// at most 64 outputs per frame; the next frame is taken only once the
// current one is done.
// Config (cfg_valid / cfg_ready): index 0 base step, index 1 target frames;
// ready is always high, writes to other indexes are dropped.
// Reset (rst_n low, synchronous) restores register defaults, clears position
// and the previous frame, and empties the pipeline. When out_stall is high
// the output register and one pipeline stage hold, and issue stops once that
// stage is full.

module adaptive_linear_audio_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  // input frames
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [alar_pkg::SampleW-1:0] in_left_sample,
  input  logic signed [alar_pkg::SampleW-1:0] in_right_sample,
  input  logic                                in_batch_start,
  input  logic [alar_pkg::FillW-1:0]          in_fill_level,
  // output frames
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [alar_pkg::SampleW-1:0] out_left,
  output logic signed [alar_pkg::SampleW-1:0] out_right,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alar_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [alar_pkg::CfgDataW-1:0]       cfg_data
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StStep = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  localparam int SumW = alar_pkg::StepW + 1;

  logic [alar_pkg::StepW-1:0]          base_r;
  logic [alar_pkg::FillW-1:0]          target_r;
  logic [1:0]                          state_r, state_nxt;
  logic [alar_pkg::StepW-1:0]          pos_r, pos_nxt;
  logic [alar_pkg::StepW-1:0]          step_r, step_nxt;
  logic [alar_pkg::CntW-1:0]           cnt_r, cnt_nxt;
  logic signed [alar_pkg::SampleW-1:0] prevl_r, prevr_r;
  logic signed [alar_pkg::SampleW-1:0] curl_r, curr_r;
  logic                                prev_load;
  logic                                s1_valid_r, s1_last_r;
  logic                                out_valid_r, out_last_r;
  logic signed [alar_pkg::SampleW-1:0] out_left_r, out_right_r;

  logic                                in_xfer;
  logic                                advance;
  logic                                s1_ready;
  logic                                pos_ge_one;
  logic                                issue;
  logic                                issue_last;
  logic [SumW-1:0]                     sum;
  logic                                step_done;
  logic [alar_pkg::StepW-1:0]          step_new;
  alar_pkg::alar_step_req_t            step_req;
  logic signed [alar_pkg::SampleW-1:0] lane_l, lane_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= alar_pkg::BaseStepRst;
      target_r <= alar_pkg::TargetRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        alar_pkg::CfgBaseStep:     base_r   <= cfg_data;
        alar_pkg::CfgTargetFrames: target_r <= cfg_data[alar_pkg::FillW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake terms
  assign in_stall = (state_r != StIdle);
  assign in_xfer  = in_valid && !in_stall;
  assign advance  = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || advance;

  // Step recompute
  assign step_req.start         = in_xfer && in_batch_start;
  assign step_req.fill_level    = in_fill_level;
  assign step_req.target_frames = target_r;

  alar_step_unit u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (step_req),
    .base_step (base_r),
    .done      (step_done),
    .step      (step_new)
  );

  // Sequencer: one output issued per cycle while position is below 1.0 and stage 1 can take it
  assign pos_ge_one = (pos_r[alar_pkg::StepW-1:alar_pkg::FracW] != '0);
  assign issue      = (state_r == StRun) && !pos_ge_one && s1_ready;
  assign sum        = {1'b0, pos_r} + {1'b0, step_r};
  assign issue_last = (sum[SumW-1:alar_pkg::FracW] != '0)
                   || (cnt_r == alar_pkg::CntW'(alar_pkg::MaxOuts - 1));

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    prev_load = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (in_xfer) begin
          state_nxt = in_batch_start ? StStep : StRun;
          cnt_nxt   = '0;
        end
      end
      StStep: begin
        if (step_done) begin
          step_nxt  = step_new;
          state_nxt = StRun;
        end
      end
      StRun: begin
        if (pos_ge_one) begin
          // frame gives no output
          pos_nxt   = pos_r - alar_pkg::OneQ28;
          prev_load = 1'b1;
          state_nxt = StIdle;
        end else if (issue) begin
          if (issue_last) begin
            pos_nxt   = (sum[SumW-1:alar_pkg::FracW] != '0)
                      ? alar_pkg::StepW'(sum - SumW'(alar_pkg::OneQ28)) : '0;
            prev_load = 1'b1;
            state_nxt = StIdle;
          end else begin
            pos_nxt = sum[alar_pkg::StepW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      pos_r   <= '0;
      step_r  <= alar_pkg::OneQ28;
      cnt_r   <= '0;
      prevl_r <= '0;
      prevr_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      if (prev_load) begin
        prevl_r <= curl_r;
        prevr_r <= curr_r;
      end
    end
  end

  // Current frame capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      curl_r <= in_left_sample;
      curr_r <= in_right_sample;
    end
  end

  // Channel lanes
  alar_lane u_lane_left (
    .clk    (clk),
    .issue  (issue),
    .prev   (prevl_r),
    .cur    (curl_r),
    .frac   (pos_r[alar_pkg::FracW-1:0]),
    .result (lane_l)
  );

  alar_lane u_lane_right (
    .clk    (clk),
    .issue  (issue),
    .prev   (prevr_r),
    .cur    (curr_r),
    .frac   (pos_r[alar_pkg::FracW-1:0]),
    .result (lane_r)
  );

  // Stage 1 control, then merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= issue;
        s1_last_r  <= issue && issue_last;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        out_last_r  <= s1_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_left_r  <= lane_l;
      out_right_r <= lane_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

`ifndef ASSERT_OFF
  a_step_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_done |-> (state_r == StStep))
    else $error("step result arrived outside step recompute");

  a_cap_forces_last: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && (cnt_r == alar_pkg::CntW'(alar_pkg::MaxOuts - 1))) |=> s1_last_r)
    else $error("output cap reached without last flag");

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != StIdle))
    else $error("accepted frame did not start work");
`endif

endmodule

// File: test/alar_frame_checker.sv
// Frame checker for the resampler: predicts every output frame and compares it.
`timescale 1ns / 1ps

module alar_frame_checker
  import alar_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [SampleW-1:0] in_left_sample,
  input  logic signed [SampleW-1:0] in_right_sample,
  input  logic                      in_batch_start,
  input  logic [FillW-1:0]          in_fill_level,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [SampleW-1:0] out_left,
  input  logic signed [SampleW-1:0] out_right,
  input  logic                      out_last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgDataW-1:0]       cfg_data,
  input  logic                      drain_done,
  output int                        mismatches,
  output int                        pending
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      last;
  } out_frame_t;

  localparam longint OneFrac    = longint'(OneQ28);
  localparam int     MaxReports = 40;

  // Predicted block state and register copies
  logic [StepW-1:0]          base_step_q;
  logic [FillW-1:0]          target_q;
  logic [StepW-1:0]          position_q;
  logic [StepW-1:0]          step_q;
  logic signed [SampleW-1:0] prev_left_q;
  logic signed [SampleW-1:0] prev_right_q;
  logic                      drain_checked;

  out_frame_t expected_frames[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    // keep the log short when the block is badly off
    if (mismatches < MaxReports) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // New step from the fill level: base times a clamped Q1.30 adjustment
  function automatic logic [StepW-1:0] rate_step(input logic [FillW-1:0] fill);
    longint tgt;
    longint adj;
    u64_t   prod;
    tgt = (target_q == '0) ? longint'(1) : longint'(target_q);
    adj = longint'(AdjOne) + ((longint'(fill) - tgt) * longint'(AdjOne)) / (RateDiv * tgt);
    if (adj < longint'(AdjMin)) adj = longint'(AdjMin);
    if (adj > longint'(AdjMax)) adj = longint'(AdjMax);
    prod = (u64_t'(base_step_q) * u64_t'(adj)) >> AdjFracW;
    return (prod > u64_t'(32'hFFFF_FFFF)) ? '1 : StepW'(prod);
  endfunction

  // Linear interpolation, truncated toward zero
  function automatic logic signed [SampleW-1:0] lerp_sample(
    input logic signed [SampleW-1:0] prev,
    input logic signed [SampleW-1:0] cur,
    input u64_t                      pos
  );
    longint acc;
    acc = longint'(prev) * OneFrac + (longint'(cur) - longint'(prev)) * longint'(pos);
    return SampleW'(acc / OneFrac);
  endfunction

  // Queue every output frame that one input frame causes
  function automatic void resample_frame(
    input logic signed [SampleW-1:0] cur_left,
    input logic signed [SampleW-1:0] cur_right,
    input logic                      batch,
    input logic [FillW-1:0]          fill
  );
    u64_t       pos;
    int         n;
    out_frame_t f;
    if (batch) step_q = rate_step(fill);
    pos = u64_t'(position_q);
    n   = 0;
    while (pos < u64_t'(OneQ28) && n < MaxOuts) begin
      f.left  = lerp_sample(prev_left_q, cur_left, pos);
      f.right = lerp_sample(prev_right_q, cur_right, pos);
      pos += u64_t'(step_q);
      n++;
      f.last = !(pos < u64_t'(OneQ28) && n < MaxOuts);
      expected_frames.push_back(f);
    end
    // hitting the output cap restarts the position at zero
    position_q   = (pos >= u64_t'(OneQ28)) ? StepW'(pos - u64_t'(OneQ28)) : '0;
    prev_left_q  = cur_left;
    prev_right_q = cur_right;
  endfunction

  always @(posedge clk) begin : watch
    out_frame_t want;
    if (!rst_n) begin
      base_step_q   = BaseStepRst;
      target_q      = TargetRst;
      position_q    = '0;
      step_q        = OneQ28;
      prev_left_q   = '0;
      prev_right_q  = '0;
      drain_checked = 1'b0;
      expected_frames.delete();
    end else begin
      // output transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("unexpected output L=%0d R=%0d last=%0b",
                                    out_left, out_right, out_last));
        end else begin
          want = expected_frames.pop_front();
          if (out_left !== want.left)
            report_mismatch($sformatf("out_left %0d, want %0d", out_left, want.left));
          if (out_right !== want.right)
            report_mismatch($sformatf("out_right %0d, want %0d", out_right, want.right));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
        end
      end
      // register writes; unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgBaseStep) base_step_q = cfg_data[StepW-1:0];
        else if (cfg_index == CfgTargetFrames) target_q = cfg_data[FillW-1:0];
      end
      // input transfer
      if (in_valid && !in_stall)
        resample_frame(in_left_sample, in_right_sample, in_batch_start, in_fill_level);
      // nothing may be left over once the run has drained
      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (expected_frames.size() != 0)
          report_mismatch($sformatf("%0d output frames never arrived",
                                    expected_frames.size()));
      end
    end
    pending = expected_frames.size();
  end

endmodule

// File: test/adaptive_linear_audio_resampler_tb.sv
// Testbench top for the resampler: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module adaptive_linear_audio_resampler_tb;
  import alar_pkg::*;

  localparam int     ClkHalf     = 10;
  localparam int     ResetCycles = 12;
  localparam int     IdlePct     = 15;
  localparam int     HoldCycles  = 300;
  // step recompute plus pipeline, with margin
  localparam int     LatencyPad  = 80;
  // hard limit in ns, with margin for the slowest run (64 outputs per frame under stalls)
  localparam longint RunLimit    = 10_000_000;

  localparam logic [StepW-1:0]   BaseStepMin = 32'd4300000;
  localparam logic [StepW-1:0]   BaseStepMax = 32'd3758096384;
  // below the usual range, so frames run into the output cap
  localparam logic [StepW-1:0]   CapBaseStep = 32'd1000000;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgTargetFrames + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgTopIdx   = '1;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SampleW-1:0] in_left_sample;
  logic signed [SampleW-1:0] in_right_sample;
  logic                      in_batch_start;
  logic [FillW-1:0]          in_fill_level;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SampleW-1:0] out_left;
  logic signed [SampleW-1:0] out_right;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;

  logic                      calm;
  logic                      hold_armed;
  logic                      drain_done;
  logic [FillW-1:0]          cur_target;
  int                        fail_count;
  int                        pending;

  adaptive_linear_audio_resampler u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_batch_start  (in_batch_start),
    .in_fill_level   (in_fill_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  alar_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_batch_start  (in_batch_start),
    .in_fill_level   (in_fill_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .drain_done      (drain_done),
    .mismatches      (fail_count),
    .pending         (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #ClkHalf;
    clk = 1'b1;
    #ClkHalf;
  end

  // Hard stop
  initial begin
    #RunLimit;
    $display("Some tests failed");
    $finish;
  end

  // Output side: random stalls, or one long hold-off when armed
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        out_stall  <= 1'b1;
        hold_armed <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // One input transfer, with an occasional gap first; entered at a falling edge
  task automatic send_frame(
    input logic signed [SampleW-1:0] left_smp,
    input logic signed [SampleW-1:0] right_smp,
    input logic                      batch,
    input logic [FillW-1:0]          fill
  );
    int gap;
    gap = (!calm && $urandom_range(0, 99) < IdlePct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= left_smp;
    in_right_sample <= right_smp;
    in_batch_start  <= batch;
    in_fill_level   <= fill;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every output has come and the block is idle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LatencyPad) @(negedge clk);
  endtask

  // One register transfer; caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [StepW-1:0] base, input logic [FillW-1:0] target);
    quiesce();
    write_reg(CfgBaseStep, base);
    write_reg(CfgTargetFrames, CfgDataW'(target));
    cfg_valid  <= 1'b0;
    cur_target  = target;
  endtask

  // Random frames; fill mostly around the target so the adjustment is not always clamped
  task automatic random_frames(input int n);
    int               span;
    logic             batch;
    logic [FillW-1:0] fill;
    span = (cur_target == '0) ? 4 : 4 * int'(cur_target);
    if (span > 65535) span = 65535;
    for (int i = 0; i < n; i++) begin
      batch = (i == 0) || ($urandom_range(0, 7) == 0);
      fill  = ($urandom_range(0, 3) == 0) ? FillW'($urandom) : FillW'($urandom_range(0, span));
      send_frame(pick_sample(), pick_sample(), batch, fill);
    end
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_left_sample  <= '0;
    in_right_sample <= '0;
    in_batch_start  <= 1'b0;
    in_fill_level   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    calm            <= 1'b0;
    hold_armed      <= 1'b0;
    drain_done      <= 1'b0;
    cur_target       = TargetRst;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: sample extremes, fill at target, empty and full
    send_frame(16'sh7FFF, 16'sh8000, 1'b1, 16'd1440);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0, 16'd0);
    send_frame(16'sh0000, 16'shFFFF, 1'b1, 16'd0);
    send_frame(16'shFFFF, 16'sh0000, 1'b1, 16'hFFFF);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0, 16'hFFFF);
    send_frame(16'sh8000, 16'sh8000, 1'b0, 16'd0);

    // smallest base step, largest target: many outputs per frame
    set_config(BaseStepMin, 16'hFFFF);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1, 16'hFFFF);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1, 16'd0);
    send_frame(16'sd12345, -16'sd12345, 1'b0, 16'd0);

    // output cap, and a zero target taken as one
    set_config(CapBaseStep, 16'd0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1, 16'hFFFF);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0, 16'd0);
    send_frame(16'sd100, -16'sd100, 1'b1, 16'd0);

    // step saturates; the frames after it give no output
    set_config(32'hFFFF_FFFF, 16'd1);
    send_frame(16'sd1000, -16'sd1000, 1'b1, 16'hFFFF);
    repeat (4) send_frame(pick_sample(), pick_sample(), 1'b0, FillW'($urandom));

    // unmapped indexes are dropped; largest base, adjustment right at the upper clamp
    quiesce();
    write_reg(CfgTopIdx, 32'hFFFF_FFFF);
    write_reg(CfgSpareIdx, 32'h0000_0000);
    cfg_valid <= 1'b0;
    set_config(BaseStepMax, 16'd2);
    send_frame(16'sh0000, 16'sh0000, 1'b1, 16'd6);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0, 16'd0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1, 16'd1);

    // near unity rate, neither side idling
    set_config($urandom_range(32'h0C00_0000, 32'h1400_0000), FillW'($urandom_range(1, 4000)));
    calm <= 1'b1;
    random_frames(60);
    calm <= 1'b0;

    // long output hold-off while frames keep coming, then a full drain
    set_config($urandom_range(BaseStepMin, 32'h0200_0000), FillW'($urandom_range(1, 65535)));
    random_frames(25);
    hold_armed <= 1'b1;
    random_frames(20);
    quiesce();
    random_frames(20);

    // fast steps: outputs are sparse
    set_config($urandom_range(32'h1400_0000, BaseStepMax), FillW'($urandom_range(1, 200)));
    random_frames(70);

    set_config(BaseStepMax, 16'hFFFF);
    random_frames(30);

    set_config($urandom_range(32'h0200_0000, 32'h0C00_0000),
               FillW'($urandom_range(100, 3000)));
    random_frames(80);

    set_config(BaseStepMin, 16'd1);
    random_frames(40);

    set_config($urandom_range(BaseStepMin, BaseStepMax), FillW'($urandom_range(1, 65535)));
    random_frames(30);

    quiesce();
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/alar_pkg.sv
design/alar_step_unit.sv
design/alar_lane.sv
design/adaptive_linear_audio_resampler.sv
test/alar_frame_checker.sv
test/adaptive_linear_audio_resampler_tb.sv
